// ===== design/lru_weight_vector_table_unit_macros.svh =====
// Assertion helpers shared by the table logic.
`ifndef LRU_WEIGHT_VECTOR_TABLE_UNIT_MACROS_SVH
`define LRU_WEIGHT_VECTOR_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LWVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LWVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lwvt_pkg.sv =====
`default_nettype none
package lwvt_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int WEIGHTS_DEF = 20;
  localparam int CNT_W       = 9;
  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    ACT_GET    = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_MISS   = 2'd1,
    STAT_ABSENT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC,
    ST_UPD,
    ST_ZERO,
    ST_RD,
    ST_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             lookup;
    logic             rot;
    logic             hit_any;
    logic             evict;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/lwvt_ram.sv =====
`default_nettype none
module lwvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1280
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/lwvt_cell.sv =====
`default_nettype none
module lwvt_cell #(
  parameter int IDX = 0,
  parameter int SW  = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lwvt_pkg::cell_ctl_t  ctl,
  input  wire logic [31:0]          key_req,
  input  wire logic [31:0]          prev_key,
  input  wire logic [SW-1:0]        prev_slot,
  input  wire logic                 prev_valid,
  input  wire logic                 sel_in,
  input  wire logic [SW-1:0]        tslot_in,
  input  wire logic [31:0]          tail_key_in,
  output logic      [31:0]          key_o,
  output logic      [SW-1:0]        slot_o,
  output logic                      valid_o,
  output logic                      hit_o,
  output logic                      sel_o,
  output logic      [SW-1:0]        tslot_o,
  output logic      [31:0]          tail_key_o
);

  logic [31:0]   key_r;
  logic [SW-1:0] slot_r;
  logic          valid_r;
  logic          hit_r;
  logic          is_tail;
  logic          is_free_head;
  logic          tgt;

  // Position in the chain is the recency rank; the tail of the valid run is
  // the least recent entry and the first invalid cell is the next free one.
  assign is_tail      = (ctl.count == lwvt_pkg::CNT_W'(IDX + 1));
  assign is_free_head = (ctl.count == lwvt_pkg::CNT_W'(IDX));
  assign tgt          = ctl.hit_any ? hit_r : (ctl.evict ? is_tail : is_free_head);
  assign sel_o        = tgt | sel_in;
  assign tslot_o      = tgt ? slot_r : tslot_in;
  assign tail_key_o   = is_tail ? key_r : tail_key_in;

  assign key_o   = key_r;
  assign slot_o  = slot_r;
  assign valid_o = valid_r;
  assign hit_o   = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      slot_r  <= SW'(IDX);
      hit_r   <= 1'b0;
    end else begin
      if (ctl.lookup) begin
        hit_r <= valid_r && (key_r == key_req);
      end
      if (ctl.rot && sel_o) begin
        valid_r <= prev_valid;
        slot_r  <= prev_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rot && sel_o) begin
      key_r <= prev_key;
    end
  end

endmodule
`default_nettype wire

// ===== design/lru_weight_vector_table_unit.sv =====
// Fully associative LRU table of weight vectors, one cell per entry in a
// chain ordered by recency: cell 0 is the most recent entry. An item goes
// through the key match and then the chain rotation, then an insert
// zeroes its vector in the weight RAM at one word a cycle, an update
// writes one word, and a get hit streams WEIGHTS words through the RAM's
// registered read port, each read waiting for a free output register.
// The next word is taken once the final result is in the output register;
// an unused action gives no result. Capacity 0 acts as 1, above ENTRIES
// as ENTRIES.
`default_nettype none
`include "lru_weight_vector_table_unit_macros.svh"
module lru_weight_vector_table_unit #(
  parameter int ENTRIES = lwvt_pkg::ENTRIES_DEF,
  parameter int WEIGHTS = lwvt_pkg::WEIGHTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [31:0] key, [36:32] weight_index, [68:37] weight_value, [71:69] zero
  input  wire logic [71:0] in_tdata,
  // [1:0] action
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [4:0] weight_index_res, [36:5] weight_value_res, [37] evicted,
  // [69:38] evicted_key, [71:70] zero
  output logic      [71:0] out_tdata,
  // [1:0] status
  output logic      [1:0]  out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int SW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int KW    = $clog2(WEIGHTS + 1);
  localparam int DEPTH = ENTRIES * WEIGHTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CN    = lwvt_pkg::CNT_W;

  lwvt_pkg::state_t    state_r, state_nxt;
  lwvt_pkg::action_t   act_r;
  lwvt_pkg::cell_ctl_t ctl;

  logic [31:0]   key_r, wval_r;
  logic [4:0]    widx_r;
  logic [6:0]    cap_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic          res_ev_r, res_ev_nxt;
  logic [31:0]   res_ek_r, res_ek_nxt;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [4:0]    out_widx_r;
  logic [31:0]   out_wval_r;
  logic          out_ev_r;
  logic [31:0]   out_ek_r;
  logic          out_last_r;

  logic          in_fire, out_free, cfg_wr;
  logic [CN-1:0] cap_eff;
  logic          evict;
  logic          ld_req, ld_out, ld_stream;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, row_base;
  logic [31:0]   ram_wdata, ram_rdata;

  logic [31:0]   c_key   [ENTRIES];
  logic [SW-1:0] c_slot  [ENTRIES];
  logic          c_valid [ENTRIES];
  logic [ENTRIES-1:0] c_hit;
  logic          c_sel   [ENTRIES];
  logic [SW-1:0] c_tslot [ENTRIES];
  logic [31:0]   c_tkey  [ENTRIES];

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {25'd0, cap_r};

  always_comb begin
    if (cap_r == 7'd0) begin
      cap_eff = CN'(1);
    end else if (CN'(cap_r) > CN'(ENTRIES)) begin
      cap_eff = CN'(ENTRIES);
    end else begin
      cap_eff = CN'(cap_r);
    end
  end

  assign evict = (act_r == lwvt_pkg::ACT_INSERT) && !ctl.hit_any &&
                 (CN'(count_r) >= cap_eff);

  // Chain of entry cells; on rotation each cell from the head to the target takes the contents of the cell before it.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [31:0]   pk;
    logic [SW-1:0] ps;
    logic          pv;
    logic          si;
    logic [SW-1:0] ti;
    logic [31:0]   tk;
    if (i == 0) begin : g_head
      assign pk = key_r;
      assign ps = c_tslot[0];
      assign pv = 1'b1;
    end else begin : g_body
      assign pk = c_key[i-1];
      assign ps = c_slot[i-1];
      assign pv = c_valid[i-1];
    end
    if (i == ENTRIES - 1) begin : g_end
      assign si = 1'b0;
      assign ti = '0;
      assign tk = 32'd0;
    end else begin : g_mid
      assign si = c_sel[i+1];
      assign ti = c_tslot[i+1];
      assign tk = c_tkey[i+1];
    end
    lwvt_cell #(.IDX(i), .SW(SW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .key_req    (key_r),
      .prev_key   (pk),
      .prev_slot  (ps),
      .prev_valid (pv),
      .sel_in     (si),
      .tslot_in   (ti),
      .tail_key_in(tk),
      .key_o      (c_key[i]),
      .slot_o     (c_slot[i]),
      .valid_o    (c_valid[i]),
      .hit_o      (c_hit[i]),
      .sel_o      (c_sel[i]),
      .tslot_o    (c_tslot[i]),
      .tail_key_o (c_tkey[i])
    );
  end

  assign row_base = AW'(slot_r) * AW'(WEIGHTS);

  lwvt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re     (ram_re),
    .raddr  (row_base + AW'(k_r)),
    .rdata_r(ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    slot_nxt       = slot_r;
    k_nxt          = k_r;
    res_status_nxt = res_status_r;
    res_ev_nxt     = res_ev_r;
    res_ek_nxt     = res_ek_r;
    ld_req         = 1'b0;
    ld_out         = 1'b0;
    ld_stream      = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = row_base + AW'(k_r);
    ram_wdata      = 32'd0;
    in_tready      = 1'b0;
    ctl.lookup     = 1'b0;
    ctl.rot        = 1'b0;
    ctl.hit_any    = |c_hit;
    ctl.evict      = 1'b0;
    ctl.count      = CN'(count_r);
    unique case (state_r)
      lwvt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          ld_req    = 1'b1;
          state_nxt = lwvt_pkg::ST_LOOKUP;
        end
      end
      lwvt_pkg::ST_LOOKUP: begin
        ctl.lookup = 1'b1;
        state_nxt  = lwvt_pkg::ST_EXEC;
      end
      lwvt_pkg::ST_EXEC: begin
        ctl.evict      = evict;
        slot_nxt       = c_tslot[0];
        k_nxt          = '0;
        res_status_nxt = lwvt_pkg::STAT_OK;
        res_ev_nxt     = 1'b0;
        res_ek_nxt     = 32'd0;
        unique case (act_r)
          lwvt_pkg::ACT_GET: begin
            if (ctl.hit_any) begin
              ctl.rot   = 1'b1;
              state_nxt = lwvt_pkg::ST_RD;
            end else begin
              res_status_nxt = lwvt_pkg::STAT_MISS;
              state_nxt      = lwvt_pkg::ST_EMIT;
            end
          end
          lwvt_pkg::ACT_INSERT: begin
            ctl.rot = 1'b1;
            if (evict) begin
              res_ev_nxt = 1'b1;
              res_ek_nxt = c_tkey[0];
            end else if (!ctl.hit_any) begin
              count_nxt = count_r + CW'(1);
            end
            state_nxt = lwvt_pkg::ST_ZERO;
          end
          lwvt_pkg::ACT_UPDATE: begin
            if (ctl.hit_any) begin
              ctl.rot   = 1'b1;
              state_nxt = lwvt_pkg::ST_UPD;
            end else begin
              res_status_nxt = lwvt_pkg::STAT_ABSENT;
              state_nxt      = lwvt_pkg::ST_EMIT;
            end
          end
          lwvt_pkg::ACT_NONE: begin
            state_nxt = lwvt_pkg::ST_IDLE;
          end
          default: begin
            state_nxt = lwvt_pkg::ST_IDLE;
          end
        endcase
      end
      lwvt_pkg::ST_UPD: begin
        // An index past the vector writes nothing but still counts as a touch.
        ram_we    = (7'(widx_r) < 7'(WEIGHTS));
        ram_waddr = row_base + AW'(widx_r);
        ram_wdata = wval_r;
        state_nxt = lwvt_pkg::ST_EMIT;
      end
      lwvt_pkg::ST_ZERO: begin
        ram_we = 1'b1;
        k_nxt  = k_r + KW'(1);
        if (k_r == KW'(WEIGHTS - 1)) begin
          state_nxt = lwvt_pkg::ST_EMIT;
        end
      end
      lwvt_pkg::ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = lwvt_pkg::ST_WAIT;
      end
      lwvt_pkg::ST_WAIT: begin
        if (out_free) begin
          ld_stream = 1'b1;
          k_nxt     = k_r + KW'(1);
          state_nxt = (k_r == KW'(WEIGHTS - 1)) ? lwvt_pkg::ST_IDLE : lwvt_pkg::ST_RD;
        end
      end
      lwvt_pkg::ST_EMIT: begin
        if (out_free) begin
          ld_out    = 1'b1;
          state_nxt = lwvt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lwvt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lwvt_pkg::ST_IDLE;
      count_r     <= '0;
      cap_r       <= lwvt_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_wr && !cfg_paddr[2]) begin
        cap_r <= cfg_pwdata[6:0];
      end
      if (ld_out || ld_stream) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    k_r          <= k_nxt;
    res_status_r <= res_status_nxt;
    res_ev_r     <= res_ev_nxt;
    res_ek_r     <= res_ek_nxt;
    if (ld_req) begin
      act_r  <= lwvt_pkg::action_t'(in_tuser);
      key_r  <= in_tdata[31:0];
      widx_r <= in_tdata[36:32];
      wval_r <= in_tdata[68:37];
    end
    if (ld_out) begin
      out_status_r <= res_status_r;
      out_widx_r   <= 5'd0;
      out_wval_r   <= 32'd0;
      out_ev_r     <= res_ev_r;
      out_ek_r     <= res_ek_r;
      out_last_r   <= 1'b1;
    end else if (ld_stream) begin
      out_status_r <= lwvt_pkg::STAT_OK;
      out_widx_r   <= 5'(k_r);
      out_wval_r   <= ram_rdata;
      out_ev_r     <= 1'b0;
      out_ek_r     <= 32'd0;
      out_last_r   <= (k_r == KW'(WEIGHTS - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'd0, out_ek_r, out_ev_r, out_wval_r, out_widx_r};

  `LWVT_ASSERT_NOW(a_hit_unique, 1'b1, $onehot0(c_hit), "key matched in more than one cell")
  `LWVT_ASSERT_NOW(a_count_bound, 1'b1, (CN'(count_r) <= CN'(ENTRIES)), "entry count overflow")
  `LWVT_ASSERT_NEXT(a_accept_lookup, in_fire, (state_r == lwvt_pkg::ST_LOOKUP), "word not looked up")

endmodule
`default_nettype wire
